@@ hdl/espi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// espi_pkg
// Shared payload, configuration types and register codes for the encoder
// speed PI controller.
// ----------------------------------------------------------------------------
package espi_pkg;

   localparam int TICKS_W    = 16;
   localparam int TARGET_W   = 16;
   localparam int SPEED_W    = 31;
   localparam int ACC_W      = 32;
   localparam int GAIN_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_NOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PAST   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_SCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_UP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_DOWN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND   = 3'd5;

   typedef struct packed {
      logic signed [31:0]         encoder_count;
      logic [TICKS_W-1:0]         elapsed_ticks;
      logic signed [TARGET_W-1:0] speed_target;
   } espi_req_type;

   typedef struct packed {
      logic signed [7:0]  drive;
      logic [SPEED_W-1:0] measured_speed;
      logic               clamped;
   } espi_rsp_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_now;
      logic signed [GAIN_W-1:0] gain_past;
      logic [GAIN_W-1:0]        speed_scale;
      logic signed [7:0]        limit_up;
      logic signed [7:0]        limit_down;
      logic [6:0]               dead_band;
   } espi_cfg_type;

   localparam espi_cfg_type CFG_RESET = '{
      gain_now:    24'sh010000,
      gain_past:   24'shFF0000,
      speed_scale: 24'h05E1E2,
      limit_up:    8'sh7F,
      limit_down:  8'sh81,
      dead_band:   7'd15
   };

endpackage
`default_nettype wire

@@ hdl/espi_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// espi_front
// Accepts readings, forms the wrapped count delta and its magnitude, flags a
// zero tick count and hands the item to the work queue.
// ----------------------------------------------------------------------------
module espi_front #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   output logic                           full,
   input  espi_pkg::espi_req_type         req_data,
   input  logic                           fifo_full,
   output logic                           fifo_push,
   output logic [COUNT_WIDTH+32:0]        fifo_data
);
   import espi_pkg::*;

   logic [COUNT_WIDTH-1:0] prev_count_ff;
   logic [COUNT_WIDTH-1:0] prev_count_in;
   logic [COUNT_WIDTH-1:0] count_now;
   logic [COUNT_WIDTH-1:0] delta;
   logic [COUNT_WIDTH-1:0] mag;
   logic                   zero_ticks;

   assign full      = fifo_full;
   assign fifo_push = push & ~fifo_full;

   always_comb begin
      count_now  = req_data.encoder_count[COUNT_WIDTH-1:0];
      delta      = count_now - prev_count_ff;
      mag        = delta[COUNT_WIDTH-1] ? (~delta + COUNT_WIDTH'(1)) : delta;
      zero_ticks = (req_data.elapsed_ticks == '0);
      fifo_data  = {mag, zero_ticks, req_data.elapsed_ticks, req_data.speed_target};
      prev_count_in = fifo_push ? count_now : prev_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
      end else begin
         prev_count_ff <= prev_count_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/espi_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// espi_fifo
// Two-entry work queue between the front and the back.
// ----------------------------------------------------------------------------
module espi_fifo #(
   parameter int WIDTH = 65
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic             rd_valid,
   output logic [WIDTH-1:0] rd_data
);
   import espi_pkg::*;

   localparam logic [1:0] FIFO_DEPTH = 2'd2;

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             wr_ok, rd_ok;

   assign full     = (count_ff == FIFO_DEPTH);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign wr_ok    = wr_en & ~full;
   assign rd_ok    = rd_en & rd_valid;

   always_comb begin
      wr_ptr_in = wr_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_ok ? ~rd_ptr_ff : rd_ptr_ff;
      case ({wr_ok, rd_ok})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/espi_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// espi_back
// Sequencer that computes speed (multiply, bit-serial divide), error, the
// velocity-form PI update, drive limits and dead band, and holds the result.
// ----------------------------------------------------------------------------
module espi_back #(
   parameter int FRACTION_BITS = 16,
   parameter int COUNT_WIDTH   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  espi_pkg::espi_cfg_type  cfg,
   input  logic                    item_valid,
   input  logic [COUNT_WIDTH+32:0] item_data,
   output logic                    item_take,
   output logic                    empty,
   input  logic                    pop,
   output espi_pkg::espi_rsp_type  rsp_data
);
   import espi_pkg::*;

   localparam int PROD_W   = COUNT_WIDTH + GAIN_W;
   localparam int HI_W     = PROD_W - SPEED_W;
   localparam int HI_CMP_W = (HI_W > TICKS_W) ? HI_W : TICKS_W;
   localparam int ERR_W    = ((TARGET_W + FRACTION_BITS > SPEED_W) ?
                              TARGET_W + FRACTION_BITS : SPEED_W) + 2;
   localparam int MUL_W    = GAIN_W + ACC_W;
   localparam int SUM_W    = MUL_W + 2;
   localparam int CMP_W    = ACC_W + 2;
   localparam logic [4:0] DIV_LAST = 5'(SPEED_W - 1);
   localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
   localparam logic [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_NEG_MAX = {1'b1, {(ACC_W-1){1'b0}}};

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SCALE    = 9'b000000010,
      ST_CHECK    = 9'b000000100,
      ST_DIV      = 9'b000001000,
      ST_ERROR    = 9'b000010000,
      ST_MUL_NOW  = 9'b000100000,
      ST_MUL_PAST = 9'b001000000,
      ST_ACCUM    = 9'b010000000,
      ST_DRIVE    = 9'b100000000
   } espi_state_type;

   espi_state_type              state_ff, state_in;
   logic [COUNT_WIDTH-1:0]      mag_ff, mag_in;
   logic [TICKS_W-1:0]          ticks_ff, ticks_in;
   logic signed [TARGET_W-1:0]  target_ff, target_in;
   logic                        zero_ff, zero_in;
   logic [PROD_W-1:0]           prod_ff, prod_in;
   logic [TICKS_W-1:0]          rem_ff, rem_in;
   logic [SPEED_W-1:0]          quo_ff, quo_in;
   logic [4:0]                  div_cnt_ff, div_cnt_in;
   logic [SPEED_W-1:0]          speed_ff, speed_in;
   logic signed [ACC_W-1:0]     err_ff, err_in;
   logic signed [ACC_W-1:0]     prev_err_ff, prev_err_in;
   logic signed [MUL_W-1:0]     mul_now_ff, mul_now_in;
   logic signed [MUL_W-1:0]     mul_past_ff, mul_past_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [ACC_W-1:0]     acc_sum_ff, acc_sum_in;
   espi_rsp_type                rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   logic [PROD_W-1:0]           scale_prod;
   logic [HI_CMP_W-1:0]         prod_hi;
   logic                        too_big;
   logic [TICKS_W:0]            trial;
   logic [TICKS_W:0]            trial_diff;
   logic                        trial_ge;
   logic [SPEED_W-1:0]          quo_step;
   logic signed [ERR_W-1:0]     tgt_sh;
   logic signed [ERR_W-1:0]     err_wide;
   logic [ERR_W-ACC_W:0]        err_top;
   logic signed [ACC_W-1:0]     err_sat;
   logic signed [ACC_W-1:0]     past_trunc;
   logic signed [GAIN_W-1:0]    mul_a;
   logic signed [ACC_W-1:0]     mul_b;
   logic signed [MUL_W-1:0]     mul_p;
   logic signed [SUM_W-1:0]     pi_sum;
   logic signed [SUM_W-1:0]     pi_shift;
   logic signed [SUM_W-1:0]     acc_wide;
   logic [SUM_W-ACC_W:0]        acc_top;
   logic signed [ACC_W-1:0]     acc_sat;
   logic signed [CMP_W-1:0]     acc_c;
   logic signed [CMP_W-1:0]     up_q;
   logic signed [CMP_W-1:0]     down_q;
   logic signed [CMP_W-1:0]     db_q;
   logic signed [ACC_W-1:0]     acc_floor;
   logic signed [ACC_W-1:0]     drive_int;
   logic signed [7:0]           drive_val;
   logic                        clamp_val;
   logic                        out_free;

   assign empty    = ~rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign out_free = ~rsp_valid_ff | pop;

   // datapath
   always_comb begin
      scale_prod = PROD_W'(mag_ff) * PROD_W'(cfg.speed_scale);

      // quotient overflows 31 bits when the high part already reaches ticks
      prod_hi = HI_CMP_W'(prod_ff[PROD_W-1:SPEED_W]);
      too_big = zero_ff | (prod_hi >= HI_CMP_W'(ticks_ff));

      trial      = {rem_ff, quo_ff[SPEED_W-1]};
      trial_ge   = (trial >= {1'b0, ticks_ff});
      trial_diff = trial - {1'b0, ticks_ff};
      quo_step   = {quo_ff[SPEED_W-2:0], trial_ge};

      tgt_sh   = ERR_W'(target_ff) <<< FRACTION_BITS;
      err_wide = tgt_sh - signed'(ERR_W'(speed_ff));
      err_top  = err_wide[ERR_W-1:ACC_W-1];
      if ((&err_top) || (~|err_top)) begin
         err_sat = err_wide[ACC_W-1:0];
      end else begin
         err_sat = err_wide[ERR_W-1] ? ACC_NEG_MAX : ACC_POS_MAX;
      end

      // previous error truncated toward zero to a whole number
      past_trunc = {prev_err_ff[ACC_W-1:FRACTION_BITS], {FRACTION_BITS{1'b0}}};
      if (prev_err_ff[ACC_W-1] && (|prev_err_ff[FRACTION_BITS-1:0])) begin
         past_trunc = past_trunc + (ACC_W'(1) << FRACTION_BITS);
      end

      // one shared multiplier for both gain products
      mul_a = (state_ff == ST_MUL_NOW) ? cfg.gain_now : cfg.gain_past;
      mul_b = (state_ff == ST_MUL_NOW) ? err_ff : past_trunc;
      mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

      pi_sum   = SUM_W'(mul_now_ff) + SUM_W'(mul_past_ff);
      pi_shift = pi_sum >>> FRACTION_BITS;
      acc_wide = SUM_W'(acc_ff) + pi_shift;
      acc_top  = acc_wide[SUM_W-1:ACC_W-1];
      if ((&acc_top) || (~|acc_top)) begin
         acc_sat = acc_wide[ACC_W-1:0];
      end else begin
         acc_sat = acc_wide[SUM_W-1] ? ACC_NEG_MAX : ACC_POS_MAX;
      end

      acc_c  = CMP_W'(acc_sum_ff);
      up_q   = CMP_W'(cfg.limit_up) <<< FRACTION_BITS;
      down_q = CMP_W'(cfg.limit_down) <<< FRACTION_BITS;
      db_q   = signed'(CMP_W'(cfg.dead_band)) <<< FRACTION_BITS;

      acc_floor = acc_sum_ff >>> FRACTION_BITS;
      drive_int = acc_floor;
      if (acc_sum_ff[ACC_W-1] && (|acc_sum_ff[FRACTION_BITS-1:0])) begin
         drive_int = acc_floor + ACC_W'(1);
      end

      clamp_val = 1'b0;
      if (acc_c > up_q) begin
         drive_val = cfg.limit_up;
         clamp_val = 1'b1;
      end else if (acc_c < down_q) begin
         drive_val = cfg.limit_down;
         clamp_val = 1'b1;
      end else if ((acc_c < db_q) && (acc_c > -db_q)) begin
         drive_val = '0;
      end else begin
         drive_val = drive_int[7:0];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      ticks_in     = ticks_ff;
      target_in    = target_ff;
      zero_in      = zero_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_cnt_in   = div_cnt_ff;
      speed_in     = speed_ff;
      err_in       = err_ff;
      prev_err_in  = prev_err_ff;
      mul_now_in   = mul_now_ff;
      mul_past_in  = mul_past_ff;
      acc_in       = acc_ff;
      acc_sum_in   = acc_sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~pop;
      item_take    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               mag_in    = item_data[COUNT_WIDTH+32:33];
               zero_in   = item_data[32];
               ticks_in  = item_data[31:16];
               target_in = item_data[15:0];
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            prod_in  = scale_prod;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (too_big) begin
               speed_in = SPEED_MAX;
               state_in = ST_ERROR;
            end else begin
               rem_in     = prod_hi[TICKS_W-1:0];
               quo_in     = prod_ff[SPEED_W-1:0];
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_diff[TICKS_W-1:0] : trial[TICKS_W-1:0];
            quo_in = quo_step;
            if (div_cnt_ff == DIV_LAST) begin
               speed_in = quo_step;
               state_in = ST_ERROR;
            end else begin
               div_cnt_in = div_cnt_ff + 5'd1;
            end
         end
         ST_ERROR: begin
            err_in   = err_sat;
            state_in = ST_MUL_NOW;
         end
         ST_MUL_NOW: begin
            mul_now_in = mul_p;
            state_in   = ST_MUL_PAST;
         end
         ST_MUL_PAST: begin
            mul_past_in = mul_p;
            prev_err_in = err_ff;
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            acc_sum_in = acc_sat;
            state_in   = ST_DRIVE;
         end
         ST_DRIVE: begin
            // hold until the result register frees up
            if (out_free) begin
               rsp_in.drive          = drive_val;
               rsp_in.measured_speed = speed_ff;
               rsp_in.clamped        = clamp_val;
               rsp_valid_in          = 1'b1;
               acc_in   = (acc_c < down_q) ? down_q[ACC_W-1:0] : acc_sum_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      ticks_ff    <= ticks_in;
      target_ff   <= target_in;
      zero_ff     <= zero_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      speed_ff    <= speed_in;
      err_ff      <= err_in;
      mul_now_ff  <= mul_now_in;
      mul_past_ff <= mul_past_in;
      acc_sum_ff  <= acc_sum_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_err_ff  <= '0;
         acc_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_err_ff  <= prev_err_in;
         acc_ff       <= acc_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/encoder_speed_pi_controller.sv @@
// Sequence: the back runs scale, check, divide, error, both gain products,
// accumulate and drive; the divide is skipped when the speed saturates (zero
// ticks or a quotient wider than 31 bits). The divider makes one bit per cycle.
// The back takes a new reading only after the last result is stored; the queue and result register absorb stalls.
// Reset: synchronous; clears the queue, the result, the previous count,
// previous error and accumulator, and loads the register defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_speed_pi_controller
// Velocity-form PI speed controller for one motor driven from encoder
// readings, with a front that takes readings and a back that computes.
// ----------------------------------------------------------------------------
module encoder_speed_pi_controller #(
   parameter int FRACTION_BITS = 16,
   parameter int COUNT_WIDTH   = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  espi_pkg::espi_req_type           req_data,
   output logic                             empty,
   input  logic                             pop,
   output espi_pkg::espi_rsp_type           rsp_data,
   input  logic                             csr_wr_en,
   input  logic [espi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [espi_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import espi_pkg::*;

   localparam int ITEM_W = COUNT_WIDTH + 33;

   espi_cfg_type      cfg_ff, cfg_in;
   logic              fifo_full;
   logic              fifo_push;
   logic [ITEM_W-1:0] fifo_wdata;
   logic              fifo_valid;
   logic [ITEM_W-1:0] fifo_rdata;
   logic              fifo_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GAIN_NOW:    cfg_in.gain_now    = csr_wdata;
            CSR_GAIN_PAST:   cfg_in.gain_past   = csr_wdata;
            CSR_SPEED_SCALE: cfg_in.speed_scale = csr_wdata;
            CSR_LIMIT_UP:    cfg_in.limit_up    = csr_wdata[7:0];
            CSR_LIMIT_DOWN:  cfg_in.limit_down  = csr_wdata[7:0];
            CSR_DEAD_BAND:   cfg_in.dead_band   = csr_wdata[6:0];
            default: begin
               // drop writes to unused indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   espi_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .fifo_full (fifo_full),
      .fifo_push (fifo_push),
      .fifo_data (fifo_wdata)
   );

   espi_fifo #(
      .WIDTH (ITEM_W)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (fifo_push),
      .wr_data  (fifo_wdata),
      .full     (fifo_full),
      .rd_en    (fifo_take),
      .rd_valid (fifo_valid),
      .rd_data  (fifo_rdata)
   );

   espi_back #(
      .FRACTION_BITS (FRACTION_BITS),
      .COUNT_WIDTH   (COUNT_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (fifo_valid),
      .item_data  (fifo_rdata),
      .item_take  (fifo_take),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
